@@ src/cartridge_key_dongle_assert.svh @@
// ----------------------------------------------------------------------------
// cartridge key dongle assertion macros
// Property checks used by the key dongle top level; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_KEY_DONGLE_ASSERT_SVH
`define CARTRIDGE_KEY_DONGLE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CKD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key dongle check failed");

// next-cycle implication
`define CKD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key dongle check failed");

`else

`define CKD_ASSERT_IMP(lbl, ante, cons)
`define CKD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ src/ckd_pkg.sv @@
// ----------------------------------------------------------------------------
// ckd_pkg
// Shared types and constants of the cartridge key dongle.
// ----------------------------------------------------------------------------
package ckd_pkg;

	// key model register codes, also used for the chosen key
	typedef enum logic [1:0] {
		KEY_NONE  = 2'd0,
		KEY_BLACK = 2'd1,
		KEY_RED   = 2'd2,
		KEY_AUTO  = 2'd3
	} key_model_t;

	// bus function codes
	localparam logic FUNC_READ   = 1'b0;
	localparam logic FUNC_STROBE = 1'b1;

	// byte driven when nothing answers
	localparam logic [7:0] BYTE_IDLE = 8'hFF;
	// upper bits of the red key byte
	localparam logic [6:0] RED_BYTE_HI = 7'h7F;

	localparam int BLACK_W = 8;
	localparam int RED_W   = 16;

	// input beat
	typedef struct packed {
		logic        func;
		logic [15:0] address;
		logic        first_access;
	} ckd_in_t;

	// result beat
	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] detected_key;
	} ckd_out_t;

	// state register control
	typedef struct packed {
		logic clear;
		logic step;
	} ckd_ctl_t;

endpackage

@@ src/ckd_black_key.sv @@
// ----------------------------------------------------------------------------
// ckd_black_key
// Black key: 8-bit registered sum-of-products array, advanced on strobes.
// ----------------------------------------------------------------------------
module ckd_black_key import ckd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ckd_ctl_t           ctl,
	input  logic [8:1]         sel,
	output logic [BLACK_W-1:0] state
);

	logic [BLACK_W-1:0] o_q;
	logic [BLACK_W-1:0] n;
	logic [8:1]         x;
	logic               rs;

	assign x = sel;

	// reset term shared by all outputs
	assign rs = x[8] & x[7] & ~x[6] & x[5] & x[4] & ~x[3] & ~x[2] & ~x[1];

	// each output is the inverse of its product sum
	always_comb begin
		n[7] = ~(rs | (o_q[6] & o_q[4] & o_q[2] & x[1]) | (o_q[5] & ~o_q[2] & x[4])
			| (~o_q[7] & ~o_q[6] & ~o_q[5] & ~o_q[4] & ~o_q[3] & o_q[2] & ~o_q[1] & x[4])
			| (~o_q[6] & ~o_q[2] & x[1]) | (o_q[7] & ~o_q[2] & x[4])
			| (~o_q[4] & ~o_q[2] & x[1]) | (~o_q[0] & x[5]));
		n[6] = ~(rs
			| (~o_q[7] & ~o_q[6] & ~o_q[5] & ~o_q[4] & ~o_q[3] & ~o_q[2] & ~o_q[1]
				& o_q[0] & x[4])
			| (o_q[6] & o_q[4] & o_q[2] & o_q[0] & x[1]) | (~o_q[2] & ~o_q[0] & x[1])
			| (~o_q[4] & ~o_q[0] & x[1]) | (o_q[7] & ~o_q[0] & x[4])
			| (~o_q[6] & ~o_q[0] & x[1]) | (~o_q[7] & x[5]));
		n[5] = ~(rs
			| (o_q[7] & o_q[6] & o_q[5] & o_q[4] & o_q[3] & o_q[2] & o_q[0] & x[1])
			| (~o_q[7] & ~o_q[5] & o_q[3] & x[4]) | (o_q[5] & ~o_q[3] & x[4])
			| (~o_q[4] & ~o_q[3] & x[1]) | (o_q[7] & ~o_q[3] & x[4])
			| (~o_q[6] & ~o_q[3] & x[1]) | (~o_q[1] & x[5]));
		n[4] = ~(rs | (o_q[7] & o_q[6] & o_q[5] & o_q[4] & o_q[2] & o_q[0] & x[1])
			| (~o_q[5] & ~o_q[2] & x[1]) | (~o_q[7] & o_q[5] & x[4])
			| (~o_q[5] & ~o_q[4] & x[1]) | (o_q[7] & ~o_q[5] & x[4])
			| (~o_q[6] & ~o_q[5] & x[1]) | (~o_q[3] & x[5]));
		n[3] = ~(rs | (o_q[7] & o_q[6] & o_q[4] & o_q[2] & o_q[0] & x[1])
			| (~o_q[7] & ~o_q[0] & x[1]) | (~o_q[7] & ~o_q[2] & x[1])
			| (~o_q[7] & ~o_q[4] & x[1]) | (~o_q[7] & ~o_q[6] & x[1])
			| (o_q[7] & x[4]) | (~o_q[5] & x[5]));
		n[2] = ~(rs
			| (o_q[7] & o_q[6] & o_q[5] & o_q[4] & o_q[3] & o_q[2] & o_q[1] & o_q[0]
				& x[1])
			| (~o_q[7] & ~o_q[5] & ~o_q[3] & o_q[1] & x[4]) | (o_q[3] & ~o_q[1] & x[4])
			| (o_q[5] & ~o_q[1] & x[4]) | (o_q[7] & ~o_q[1] & x[4])
			| (~o_q[6] & ~o_q[1] & x[1]) | (~o_q[6] & x[5]));
		n[1] = ~(rs | (~o_q[7] & o_q[6] & ~o_q[5] & ~o_q[3] & ~o_q[1] & x[4])
			| (~o_q[6] & o_q[1] & x[4]) | (~o_q[6] & o_q[3] & x[4])
			| (~o_q[6] & o_q[5] & x[4]) | (o_q[7] & ~o_q[6] & x[4])
			| (o_q[6] & x[1]) | (~o_q[4] & x[5]));
		n[0] = ~(rs | (~o_q[7] & ~o_q[6] & ~o_q[5] & o_q[4] & ~o_q[3] & ~o_q[1] & x[4])
			| (o_q[6] & o_q[4] & x[1]) | (~o_q[4] & o_q[3] & x[4])
			| (o_q[5] & ~o_q[4] & x[4]) | (o_q[7] & ~o_q[4] & x[4])
			| (~o_q[6] & ~o_q[4] & x[1]) | (~o_q[2] & x[5]));
	end

	// registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q <= '0;
		end else if (ctl.clear) begin
			o_q <= '0;
		end else if (ctl.step) begin
			o_q <= n;
		end
	end

	assign state = o_q;

endmodule

@@ src/ckd_red_key.sv @@
// ----------------------------------------------------------------------------
// ckd_red_key
// Red key: chain of 16 toggle flip-flops, advanced on first reads.
// ----------------------------------------------------------------------------
module ckd_red_key import ckd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ckd_ctl_t         ctl,
	input  logic             s,
	output logic [RED_W-1:0] state
);

	logic [RED_W-1:0] b_q;
	logic [RED_W-1:0] t;
	logic [RED_W-1:0] hi;
	logic             al;

	assign al = ~s;

	// hi[i]: all lower flip-flops set
	always_comb begin
		for (int i = 0; i < RED_W; i++) begin
			hi[i] = &(b_q | ~((RED_W'(1) << i) - RED_W'(1)));
		end
	end

	// toggle terms
	always_comb begin
		t[0]  = (~b_q[0] & ~s) | (b_q[0] & s);
		t[1]  = (~b_q[1] & s) | (b_q[0] & ~b_q[1] & ~s) | (b_q[0] & b_q[1] & s);
		t[2]  = (b_q[0] & ~b_q[2] & s) | (b_q[1] & b_q[2] & s) | (hi[2] & ~b_q[2] & ~s);
		t[3]  = (b_q[0] & ~b_q[3] & ~s) | (b_q[1] & ~b_q[2] & b_q[3])
			| (hi[3] & ~b_q[3] & ~s);
		t[4]  = (~b_q[0] & b_q[2] & ~b_q[4]) | (~b_q[1] & ~b_q[3] & b_q[4] & s)
			| (hi[4] & ~b_q[4] & ~s);
		t[5]  = (~b_q[0] & ~b_q[2] & b_q[4] & ~b_q[5]) | (~b_q[1] & b_q[3] & b_q[5] & s)
			| (hi[5] & ~b_q[5] & ~s);
		t[6]  = (~b_q[4] & b_q[5] & ~b_q[6]) | (b_q[1] & ~b_q[2] & ~b_q[3] & b_q[6])
			| (hi[6] & ~b_q[6] & ~s);
		t[7]  = (~b_q[1] & b_q[4] & ~b_q[5] & ~b_q[7]) | (b_q[2] & b_q[3] & ~b_q[6] & b_q[7])
			| (hi[7] & ~b_q[7] & ~s);
		t[8]  = (~b_q[4] & b_q[5] & ~b_q[8]) | (~b_q[3] & b_q[6] & ~b_q[7] & b_q[8])
			| (al & hi[8] & ~b_q[8]);
		t[9]  = (~b_q[6] & ~b_q[8] & b_q[9]) | (~b_q[5] & b_q[7] & ~b_q[9])
			| (al & hi[9] & ~b_q[9]);
		t[10] = (~b_q[5] & b_q[10]) | (~b_q[7] & ~b_q[9] & ~b_q[10])
			| (al & hi[10] & ~b_q[10]);
		t[11] = (~b_q[8] & b_q[9] & b_q[11]) | (b_q[5] & ~b_q[7] & b_q[10] & ~b_q[11])
			| (al & hi[11] & ~b_q[11]);
		t[12] = (b_q[7] & ~b_q[8] & ~b_q[12]) | (b_q[9] & ~b_q[10] & b_q[11] & b_q[12])
			| (al & hi[12] & ~b_q[12]);
		t[13] = (~b_q[9] & ~b_q[12] & ~b_q[13]) | (b_q[10] & ~b_q[11] & b_q[13])
			| (al & hi[13] & ~b_q[13]);
		t[14] = (~b_q[10] & b_q[11] & ~b_q[14]) | (~b_q[9] & b_q[12] & ~b_q[13] & b_q[14])
			| (al & hi[14] & ~b_q[14]);
		t[15] = (~b_q[1] & b_q[15]) | (b_q[2] & s & ~b_q[15])
			| (b_q[6] & ~s & ~b_q[9] & ~b_q[11] & b_q[15])
			| (~b_q[3] & b_q[6] & s & b_q[10] & ~b_q[14] & b_q[15])
			| (al & hi[15] & ~b_q[15]);
	end

	// toggle flip-flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (ctl.clear) begin
			b_q <= '0;
		end else if (ctl.step) begin
			b_q <= b_q ^ t;
		end
	end

	assign state = b_q;

endmodule

@@ src/cartridge_key_dongle.sv @@
// ----------------------------------------------------------------------------
// cartridge_key_dongle
// Copy-protection key on a cartridge ROM port: black or red key, auto-detect.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// in        input      in_valid / in_ready         ckd_in_t  (func, address, first_access)
// out       output     out_valid / out_ready       ckd_out_t (read_data, detected_key)
// cfg       input      cfg_wr_en                   cfg_wr_data (key model, 2 bits)
//
// one beat per cycle sustained while out is ready; a beat passes through the
// input register and then the result register before it appears on out.
// key state is updated as the beat moves from the input register into the
// result register, so the next beat sees it without a bubble.
// a stalled out holds the result; the input register still takes one more beat.
// reset and a cfg write both return the key state to its initial value.
//
`include "cartridge_key_dongle_assert.svh"

module cartridge_key_dongle import ckd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ckd_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output ckd_out_t   out_data,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data
);

	logic               valid_s1;
	ckd_in_t            in_s1;
	logic               valid_q;
	ckd_out_t           out_q;
	key_model_t         model_q;
	key_model_t         chosen_q;
	logic               locked_q;

	logic               advance;
	logic               detect;
	key_model_t         chosen_nx;
	logic [7:0]         data_nx;
	ckd_ctl_t           black_ctl;
	ckd_ctl_t           red_ctl;
	logic [BLACK_W-1:0] black_state;
	logic [RED_W-1:0]   red_state;
	key_model_t         cfg_model;

	assign cfg_model = key_model_t'(cfg_wr_data);

	// handshake and stage movement
	assign advance  = valid_s1 & (~valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// key detection and read data
	always_comb begin
		detect    = 1'b0;
		chosen_nx = chosen_q;
		data_nx   = BYTE_IDLE;
		if (in_s1.func == FUNC_READ && model_q != KEY_NONE) begin
			detect = ~locked_q & in_s1.first_access;
			if (detect) begin
				chosen_nx = (|in_s1.address[7:1]) ? KEY_BLACK : KEY_RED;
			end
			if (!in_s1.address[0]) begin
				unique case (chosen_nx)
					KEY_BLACK: data_nx = black_state;
					KEY_RED:   data_nx = {RED_BYTE_HI, red_state[RED_W-1]};
					default:   data_nx = BYTE_IDLE;
				endcase
			end
		end
	end

	// key clocking
	assign black_ctl.clear = cfg_wr_en;
	assign black_ctl.step  = advance & (in_s1.func == FUNC_STROBE) & (chosen_q == KEY_BLACK);
	assign red_ctl.clear   = cfg_wr_en;
	assign red_ctl.step    = advance & (in_s1.func == FUNC_READ) & (model_q != KEY_NONE)
		& in_s1.first_access & (chosen_nx == KEY_RED);

	ckd_black_key u_black (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (black_ctl),
		.sel    (in_s1.address[8:1]),
		.state  (black_state)
	);

	ckd_red_key u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (red_ctl),
		.s      (in_s1.address[8]),
		.state  (red_state)
	);

	// model, chosen key and lock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q  <= KEY_NONE;
			chosen_q <= KEY_NONE;
			locked_q <= 1'b1;
		end else if (cfg_wr_en) begin
			model_q  <= cfg_model;
			chosen_q <= (cfg_model == KEY_AUTO) ? KEY_NONE : cfg_model;
			locked_q <= (cfg_model != KEY_AUTO);
		end else if (advance && detect) begin
			chosen_q <= chosen_nx;
			locked_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.read_data    <= data_nx;
			out_q.detected_key <= chosen_nx;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = out_q;

	// checks
	`CKD_ASSERT_IMP(a_answer_needs_key, out_valid && out_data.read_data != BYTE_IDLE, out_data.detected_key != KEY_NONE)
	`CKD_ASSERT_IMP(a_lock_unless_auto, model_q != KEY_AUTO, locked_q)
	`CKD_ASSERT_NXT(a_locked_key_holds, locked_q && !cfg_wr_en, $stable(chosen_q))
	`CKD_ASSERT_IMP(a_stall_needs_beat, !in_ready, valid_s1 && valid_q)

endmodule
